/* design/ccwh_pkg.sv */
`default_nettype none

package ccwh_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int NUM_BINS    = 256;
    localparam int BIN_WIDTH   = $clog2(NUM_BINS);
    localparam int NUM_LANES   = 3;
    localparam int DIV_STEPS   = 8;
    localparam int STEP_WIDTH  = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        REG_RED_LOW    = 3'd0,
        REG_RED_HIGH   = 3'd1,
        REG_GREEN_LOW  = 3'd2,
        REG_GREEN_HIGH = 3'd3,
        REG_BLUE_LOW   = 3'd4,
        REG_BLUE_HIGH  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        LANE_RED   = 2'd0,
        LANE_GREEN = 2'd1,
        LANE_BLUE  = 2'd2
    } t_lane;

    // one histogram row holds the red, green and blue counters of one bin
    typedef logic [NUM_LANES-1:0][COUNT_WIDTH-1:0] t_row;

    typedef struct packed {
        logic                 rd;
        logic                 inc;
        logic                 clr;
        logic [BIN_WIDTH-1:0] addr;
        t_lane                lane;
    } t_hist_req;

endpackage

`default_nettype wire

/* design/ccwh_chan.sv */
`default_nettype none

module ccwh_chan (
    input  wire logic       i_clk,
    input  wire logic       i_load,
    input  wire logic       i_step,
    input  wire logic [7:0] i_value,
    input  wire logic [7:0] i_low,
    input  wire logic [7:0] i_high,
    output logic      [7:0] o_value
);

    logic        w_lt;
    logic        w_eq;
    logic [7:0]  w_mid;
    logic        w_below;
    logic [7:0]  w_mul_a;
    logic [7:0]  w_mul_b;
    logic [7:0]  w_div;
    logic [7:0]  w_off;
    logic        w_zero;
    logic [15:0] w_prod;
    logic [8:0]  w_shift;
    logic        w_ge;
    logic [7:0]  w_sub;

    logic [15:0] r_acc;
    logic [7:0]  r_div;
    logic [7:0]  r_off;
    logic        r_zero;

    function automatic logic [6:0] w_sub_lh(input logic [7:0] lo, input logic [7:0] hi);
        logic [7:0] d;
        d = lo - hi;
        return d[7:1];
    endfunction

    // pick the segment of the curve and set up numerator factors, divisor and offset
    always_comb begin
        w_lt    = i_low < i_high;
        w_eq    = i_low == i_high;
        w_mid   = i_high + {1'b0, w_sub_lh(i_low, i_high)};
        w_below = i_value <= w_mid;
        if (w_lt) begin
            w_mul_a = i_high - i_low;
            w_mul_b = i_value;
            w_div   = 8'hFF;
            w_off   = i_low;
        end else if (w_below) begin
            w_mul_a = i_value;
            w_mul_b = i_high;
            w_div   = w_mid;
            w_off   = 8'd0;
        end else begin
            w_mul_a = i_value - w_mid;
            w_mul_b = 8'hFF - i_low;
            w_div   = 8'hFF - w_mid;
            w_off   = i_low;
        end
        w_zero = w_eq || (!w_lt && w_below && (w_mid == 8'd0));
        w_prod = 16'(w_mul_a) * 16'(w_mul_b);
    end

    // restoring divide, one quotient bit a step; the quotient always fits 8 bits
    always_comb begin
        w_shift = {r_acc[15:8], r_acc[7]};
        w_ge    = w_shift >= {1'b0, r_div};
        w_sub   = w_shift[7:0] - r_div;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc  <= w_prod;
            r_div  <= w_div;
            r_off  <= w_off;
            r_zero <= w_zero;
        end else if (i_step) begin
            if (w_ge) begin
                r_acc <= {w_sub, r_acc[6:0], 1'b1};
            end else begin
                r_acc <= {w_shift[7:0], r_acc[6:0], 1'b0};
            end
        end
    end

    assign o_value = r_zero ? 8'd0 : r_off + r_acc[7:0];

endmodule

`default_nettype wire

/* design/ccwh_hist.sv */
`default_nettype none

module ccwh_hist (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ccwh_pkg::t_hist_req i_req,
    output ccwh_pkg::t_row          o_row
);

    ccwh_pkg::t_row                     r_mem [ccwh_pkg::NUM_BINS];
    logic [ccwh_pkg::NUM_BINS-1:0]      r_valid;
    ccwh_pkg::t_row                     r_rd_row;
    logic                               r_rd_vld;
    ccwh_pkg::t_row                     w_cur;
    ccwh_pkg::t_row                     w_wr_row;

    // a row never written since the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_valid <= '0;
            end else if (i_req.inc) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd) begin
                r_rd_vld <= r_valid[i_req.addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rd_row <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.inc) begin
            r_mem[i_req.addr] <= w_wr_row;
        end
    end

    // increment goes back to the row read in the cycle before
    always_comb begin
        w_cur              = r_rd_vld ? r_rd_row : '0;
        w_wr_row           = w_cur;
        w_wr_row[i_req.lane] = w_cur[i_req.lane] + ccwh_pkg::COUNT_WIDTH'(1);
    end

    assign o_row = w_cur;

endmodule

`default_nettype wire

/* design/color_clamp_with_histogram_core.sv */
`default_nettype none

// channel   direction  handshake                 payload
// in        sink       i_in_valid / o_in_stall   i_command, i_pixel_in, i_bin_index
// out       source     o_out_valid / i_out_stall o_pixel_out, o_red_count, o_green_count,
//                                                o_blue_count
// cfg       sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// pixel: from transfer to the next possible transfer come one setup state, eight
// steps of the per-channel divider, a read and a write of the histogram memory for each
// of the three channels, the hand-over of the result and the idle state.
// bin read: capture state, hand-over, idle; clear and unused commands: hand-over, idle.
// clear marks all 256 rows invalid at once, so no sweep follows reset or a clear.
// o_in_stall is low only while idle; a result waits in the output register under
// i_out_stall, and only the next result behind it is held back.

module color_clamp_with_histogram_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_pixel_in,
    input  wire logic [7:0]  i_bin_index,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_pixel_out,
    output logic [31:0]      o_red_count,
    output logic [31:0]      o_green_count,
    output logic [31:0]      o_blue_count,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_WR   = 7'b0010000,
        S_RCAP = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [ccwh_pkg::STEP_WIDTH-1:0] r_step, n_step;
    ccwh_pkg::t_lane                 r_lane, n_lane;

    logic [7:0]  r_red_low, r_red_high, r_green_low, r_green_high, r_blue_low, r_blue_high;
    logic [31:0] r_pix;

    logic [31:0] r_res_pix, r_res_red, r_res_green, r_res_blue;
    logic        r_out_valid;
    logic [31:0] r_out_pix, r_out_red, r_out_green, r_out_blue;

    logic                w_accept;
    logic                w_out_free;
    logic                w_load;
    logic                w_step;
    logic [7:0]          w_red, w_green, w_blue;
    ccwh_pkg::t_hist_req w_req;
    ccwh_pkg::t_row      w_row;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = r_state == S_LOAD;
    assign w_step     = r_state == S_DIV;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_low    <= 8'd0;
            r_red_high   <= 8'hFF;
            r_green_low  <= 8'd0;
            r_green_high <= 8'hFF;
            r_blue_low   <= 8'd0;
            r_blue_high  <= 8'hFF;
        end else if (i_cfg_we) begin
            case (ccwh_pkg::t_reg_idx'(i_cfg_index))
                ccwh_pkg::REG_RED_LOW:    r_red_low    <= i_cfg_data;
                ccwh_pkg::REG_RED_HIGH:   r_red_high   <= i_cfg_data;
                ccwh_pkg::REG_GREEN_LOW:  r_green_low  <= i_cfg_data;
                ccwh_pkg::REG_GREEN_HIGH: r_green_high <= i_cfg_data;
                ccwh_pkg::REG_BLUE_LOW:   r_blue_low   <= i_cfg_data;
                ccwh_pkg::REG_BLUE_HIGH:  r_blue_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ccwh_chan u_red (
        .i_clk   (i_clk),
        .i_load  (w_load),
        .i_step  (w_step),
        .i_value (r_pix[23:16]),
        .i_low   (r_red_low),
        .i_high  (r_red_high),
        .o_value (w_red)
    );

    ccwh_chan u_green (
        .i_clk   (i_clk),
        .i_load  (w_load),
        .i_step  (w_step),
        .i_value (r_pix[15:8]),
        .i_low   (r_green_low),
        .i_high  (r_green_high),
        .o_value (w_green)
    );

    ccwh_chan u_blue (
        .i_clk   (i_clk),
        .i_load  (w_load),
        .i_step  (w_step),
        .i_value (r_pix[7:0]),
        .i_low   (r_blue_low),
        .i_high  (r_blue_high),
        .o_value (w_blue)
    );

    // histogram memory requests
    always_comb begin
        w_req      = '0;
        w_req.lane = r_lane;
        case (r_lane)
            ccwh_pkg::LANE_RED:   w_req.addr = w_red;
            ccwh_pkg::LANE_GREEN: w_req.addr = w_green;
            ccwh_pkg::LANE_BLUE:  w_req.addr = w_blue;
            default:              w_req.addr = w_red;
        endcase
        case (r_state)
            S_IDLE: begin
                w_req.addr = i_bin_index;
                if (w_accept) begin
                    w_req.rd  = ccwh_pkg::t_cmd'(i_command) == ccwh_pkg::CMD_READ;
                    w_req.clr = ccwh_pkg::t_cmd'(i_command) == ccwh_pkg::CMD_CLEAR;
                end
            end
            S_RD:    w_req.rd  = 1'b1;
            S_WR:    w_req.inc = 1'b1;
            default: ;
        endcase
    end

    ccwh_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_row   (w_row)
    );

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_lane  = r_lane;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (ccwh_pkg::t_cmd'(i_command))
                        ccwh_pkg::CMD_PIXEL: n_state = S_LOAD;
                        ccwh_pkg::CMD_READ:  n_state = S_RCAP;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == ccwh_pkg::STEP_WIDTH'(ccwh_pkg::DIV_STEPS - 1)) begin
                    n_state = S_RD;
                    n_lane  = ccwh_pkg::LANE_RED;
                end
            end
            S_RD: n_state = S_WR;
            S_WR: begin
                case (r_lane)
                    ccwh_pkg::LANE_RED: begin
                        n_lane  = ccwh_pkg::LANE_GREEN;
                        n_state = S_RD;
                    end
                    ccwh_pkg::LANE_GREEN: begin
                        n_lane  = ccwh_pkg::LANE_BLUE;
                        n_state = S_RD;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RCAP: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_lane  <= ccwh_pkg::LANE_RED;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_lane  <= n_lane;
        end
    end

    // result assembly
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix       <= i_pixel_in;
            r_res_pix   <= '0;
            r_res_red   <= '0;
            r_res_green <= '0;
            r_res_blue  <= '0;
        end
        if ((r_state == S_WR) && (r_lane == ccwh_pkg::LANE_BLUE)) begin
            r_res_pix <= {8'hFF, w_red, w_green, w_blue};
        end
        if (r_state == S_RCAP) begin
            r_res_red   <= 32'(w_row[ccwh_pkg::LANE_RED]);
            r_res_green <= 32'(w_row[ccwh_pkg::LANE_GREEN]);
            r_res_blue  <= 32'(w_row[ccwh_pkg::LANE_BLUE]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_pix   <= r_res_pix;
            r_out_red   <= r_res_red;
            r_out_green <= r_res_green;
            r_out_blue  <= r_res_blue;
        end
    end

    assign o_in_stall    = r_state != S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_pixel_out   = r_out_pix;
    assign o_red_count   = r_out_red;
    assign o_green_count = r_out_green;
    assign o_blue_count  = r_out_blue;

endmodule

`default_nettype wire
